// ===== sv/palette_error_diffusion_dither_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette dither block
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_MACROS_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PEDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PEDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== sv/pedd_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette dither package
// Types and constants shared by the palette dither block.
// ----------------------------------------------------------------------------
`default_nettype none
package pedd_pkg;
	localparam int unsigned MaxWidthDef = 1024;
	localparam int unsigned PaletteDepthDef = 256;
	localparam int unsigned MaxHeight = 4096;
	localparam logic [19:0] DistInit = 20'(255 * 255 * 3 + 1);

	localparam logic [1:0] RegWidth = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegPalSize = 2'd2;

	localparam logic OpPalette = 1'b0;
	localparam logic OpPixel = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ADD,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_ERR,
		ST_TAIL,
		ST_SPREAD,
		ST_OUT
	} state_t;

	// Floor of e*k/16 for a signed error.
	function automatic logic signed [7:0] spread(input logic signed [8:0] e,
		input logic [2:0] k);
		logic signed [12:0] p;
		begin
			p = 13'(e) * $signed({10'd0, k});
			spread = 8'(p >>> 4);
		end
	endfunction

	function automatic logic [7:0] add_clamp(input logic [7:0] v,
		input logic signed [7:0] t);
		logic signed [9:0] s;
		begin
			s = $signed({2'b00, v}) + 10'(t);
			if (s < 0) begin
				add_clamp = 8'd0;
			end else if (s > 10'sd255) begin
				add_clamp = 8'd255;
			end else begin
				add_clamp = s[7:0];
			end
		end
	endfunction
endpackage
`default_nettype wire

// ===== sv/palette_error_diffusion_dither.sv =====
// ----------------------------------------------------------------------------
// Palette error diffusion dither
// Nearest palette colour search with Floyd-Steinberg error spreading.
// ----------------------------------------------------------------------------
// Palette writes and pixels share the input stream, the op flag in tuser telling
// them apart. A palette write leaves the block in its idle state, so the input
// stays ready. A pixel keeps the input not ready until it is through: the column
// term memory is read, the three column terms and the right term are added one
// by one, the palette read is primed, one squared-distance unit compares one
// palette entry a cycle, and the error, the end-of-row term write, the spread and
// the output step follow in turn. A finished word waits in the output register
// while the next word is taken; a pixel holds in its output step only while the
// word before it has not been taken.
`default_nettype none
module palette_error_diffusion_dither #(
	parameter int unsigned MAX_WIDTH = pedd_pkg::MaxWidthDef,
	parameter int unsigned PALETTE_DEPTH = pedd_pkg::PaletteDepthDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32]
	input wire logic [39:0] s_tdata,
	// tuser: op
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: color_index[7:0]
	output logic [7:0] m_tdata,
	output logic m_tlast,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [8:0] palsize_q;

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [71:0] row_mem [MAX_WIDTH];
	logic [23:0] pal_rd_q;
	logic [71:0] row_rd_q;

	pedd_pkg::state_t state_q, state_d;
	logic [CW-1:0] x_q;
	logic [12:0] y_q;
	logic [7:0] v_q [3];
	logic [7:0] a_q;
	logic signed [7:0] right_q [3];
	logic [15:0] near_q [3];
	logic [7:0] far_q [3];
	logic [1:0] step_q;
	logic [8:0] idx_q;
	logic [8:0] cand_q;
	logic [19:0] min_q;
	logic [7:0] best_q;
	logic [23:0] best_rgb_q;
	logic signed [8:0] e_q [3];
	logic [CW-1:0] w_eff, x_eff;
	logic [12:0] h_eff, y_eff;
	logic [8:0] ps_eff;
	logic last_col, last_row;
	logic in_acc, out_acc, cfg_wr;
	logic [19:0] sq_dist;
	logic [71:0] wr_row;
	logic row_we, fe_q;
	logic out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == pedd_pkg::ST_IDLE);

	always_comb begin
		case (paddr[3:2])
			pedd_pkg::RegWidth: prdata = {21'd0, width_q};
			pedd_pkg::RegHeight: prdata = {19'd0, height_q};
			pedd_pkg::RegPalSize: prdata = {23'd0, palsize_q};
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = 13'd1;
		end else if (32'(height_q) > pedd_pkg::MaxHeight) begin
			h_eff = 13'(pedd_pkg::MaxHeight);
		end else begin
			h_eff = height_q;
		end
		if (palsize_q == 9'd0) begin
			ps_eff = 9'd1;
		end else if (32'(palsize_q) > PALETTE_DEPTH) begin
			ps_eff = 9'(PALETTE_DEPTH);
		end else begin
			ps_eff = palsize_q;
		end
		x_eff = (x_q >= w_eff) ? w_eff - CW'(1) : x_q;
		y_eff = (y_q >= h_eff) ? h_eff - 13'd1 : y_q;
		last_col = (x_eff + CW'(1)) >= w_eff;
		last_row = (y_eff + 13'd1) >= h_eff;
	end

	// Shared distance unit: one palette entry per cycle.
	always_comb begin
		logic signed [8:0] dr, dg, db;
		logic signed [17:0] pr, pg, pb;
		dr = $signed({1'b0, v_q[0]}) - $signed({1'b0, pal_rd_q[23:16]});
		dg = $signed({1'b0, v_q[1]}) - $signed({1'b0, pal_rd_q[15:8]});
		db = $signed({1'b0, v_q[2]}) - $signed({1'b0, pal_rd_q[7:0]});
		pr = 18'(dr) * 18'(dr);
		pg = 18'(dg) * 18'(dg);
		pb = 18'(db) * 18'(db);
		sq_dist = 20'(pr) + 20'(pg) + 20'(pb);
	end

	always_comb begin
		logic [7:0] t3 [3];
		logic [7:0] t5 [3];
		for (int c = 0; c < 3; c++) begin
			t3[c] = pedd_pkg::spread(e_q[c], 3'd3);
			t5[c] = pedd_pkg::spread(e_q[c], 3'd5);
		end
		if (state_q == pedd_pkg::ST_TAIL) begin
			wr_row = {8'd0, t5[2], far_q[2], 8'd0, t5[1], far_q[1],
				8'd0, t5[0], far_q[0]};
		end else begin
			wr_row = {t3[2], near_q[2], t3[1], near_q[1], t3[0], near_q[0]};
		end
		row_we = ((state_q == pedd_pkg::ST_TAIL) && last_col) ||
			((state_q == pedd_pkg::ST_SPREAD) && x_eff != CW'(0));
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == pedd_pkg::OpPalette &&
			32'(s_tdata[7:0]) < PALETTE_DEPTH) begin
			pal_mem[s_tdata[PW-1:0]] <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
		end
		pal_rd_q <= pal_mem[idx_q[PW-1:0]];
		if (row_we) begin
			row_mem[(state_q == pedd_pkg::ST_TAIL) ? x_eff[XW-1:0] :
				XW'(x_eff - CW'(1))] <= wr_row;
		end
		row_rd_q <= row_mem[x_eff[XW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pedd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pedd_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == pedd_pkg::OpPixel) state_d = pedd_pkg::ST_READ;
			end
			pedd_pkg::ST_READ: state_d = pedd_pkg::ST_ADD;
			pedd_pkg::ST_ADD: if (step_q == 2'd3) state_d = pedd_pkg::ST_SEARCH_WAIT;
			pedd_pkg::ST_SEARCH_WAIT: state_d = pedd_pkg::ST_SEARCH;
			pedd_pkg::ST_SEARCH: begin
				if (cand_q + 9'd1 >= ps_eff) state_d = pedd_pkg::ST_ERR;
			end
			pedd_pkg::ST_ERR: state_d = pedd_pkg::ST_TAIL;
			pedd_pkg::ST_TAIL: state_d = pedd_pkg::ST_SPREAD;
			pedd_pkg::ST_SPREAD: state_d = pedd_pkg::ST_OUT;
			pedd_pkg::ST_OUT: if (out_free) state_d = pedd_pkg::ST_IDLE;
			default: state_d = pedd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1;
			height_q <= 13'd1;
			palsize_q <= 9'd1;
			x_q <= '0;
			y_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= 8'd0;
			m_tlast <= 1'b0;
			step_q <= 2'd0;
			idx_q <= 9'd0;
			cand_q <= 9'd0;
			min_q <= 20'd0;
			best_q <= 8'd0;
			fe_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				right_q[c] <= 8'sd0;
				near_q[c] <= 16'd0;
				far_q[c] <= 8'd0;
			end
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					pedd_pkg::RegWidth: width_q <= pwdata[10:0];
					pedd_pkg::RegHeight: height_q <= pwdata[12:0];
					pedd_pkg::RegPalSize: palsize_q <= pwdata[8:0];
					default: ;
				endcase
			end
			if (state_q == pedd_pkg::ST_OUT && out_free) begin
				m_tvalid <= 1'b1;
				m_tdata <= (a_q != 8'd0) ? best_q : 8'd0;
				m_tlast <= fe_q;
			end else if (out_acc) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				pedd_pkg::ST_IDLE: begin
					step_q <= 2'd0;
					idx_q <= 9'd0;
				end
				pedd_pkg::ST_ADD: begin
					step_q <= step_q + 2'd1;
					cand_q <= 9'd0;
					min_q <= pedd_pkg::DistInit;
				end
				pedd_pkg::ST_SEARCH_WAIT: idx_q <= 9'd1;
				pedd_pkg::ST_SEARCH: begin
					if (sq_dist < min_q) begin
						min_q <= sq_dist;
						best_q <= cand_q[7:0];
					end
					cand_q <= cand_q + 9'd1;
					idx_q <= idx_q + 9'd1;
				end
				pedd_pkg::ST_SPREAD: begin
					for (int c = 0; c < 3; c++) begin
						right_q[c] <= last_col ? 8'sd0 : pedd_pkg::spread(e_q[c], 3'd7);
						near_q[c] <= last_col ? 16'd0 :
							{pedd_pkg::spread(e_q[c], 3'd5), far_q[c]};
						far_q[c] <= last_col ? 8'd0 : pedd_pkg::spread(e_q[c], 3'd1);
					end
					if (last_col) begin
						x_q <= '0;
						y_q <= last_row ? 13'd0 : y_eff + 13'd1;
					end else begin
						x_q <= x_eff + CW'(1);
					end
					fe_q <= last_col && last_row;
				end
				default: ;
			endcase
		end
	end

	// Pixel payload and error registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q[0] <= s_tdata[15:8];
			v_q[1] <= s_tdata[23:16];
			v_q[2] <= s_tdata[31:24];
			a_q <= s_tdata[39:32];
		end
		if (state_q == pedd_pkg::ST_ADD) begin
			if (a_q != 8'd0) begin
				for (int c = 0; c < 3; c++) begin
					if (step_q == 2'd3) begin
						v_q[c] <= pedd_pkg::add_clamp(v_q[c], right_q[c]);
					end else if (y_eff != 13'd0) begin
						v_q[c] <= pedd_pkg::add_clamp(v_q[c],
							row_rd_q[24*c + 8*step_q +: 8]);
					end
				end
			end
		end
		if (state_q == pedd_pkg::ST_SEARCH && sq_dist < min_q) begin
			best_rgb_q <= pal_rd_q;
		end
		if (state_q == pedd_pkg::ST_ERR) begin
			e_q[0] <= (a_q != 8'd0) ? $signed({1'b0, v_q[0]}) -
				$signed({1'b0, best_rgb_q[23:16]}) : 9'sd0;
			e_q[1] <= (a_q != 8'd0) ? $signed({1'b0, v_q[1]}) -
				$signed({1'b0, best_rgb_q[15:8]}) : 9'sd0;
			e_q[2] <= (a_q != 8'd0) ? $signed({1'b0, v_q[2]}) -
				$signed({1'b0, best_rgb_q[7:0]}) : 9'sd0;
		end
	end

	`include "palette_error_diffusion_dither_macros.svh"

	`PEDD_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != pedd_pkg::ST_IDLE, !s_tready)
	`PEDD_ASSERT_NEXT(a_out_follows, clk, arst_n, state_q == pedd_pkg::ST_OUT, m_tvalid)
	`PEDD_ASSERT_IMP(a_search_bound, clk, arst_n, state_q == pedd_pkg::ST_SEARCH, cand_q < ps_eff)
endmodule
`default_nettype wire
